>>> hw/rtl/first_fit_block_allocator_defines.svh
// Assertion macros shared by the first-fit block allocator RTL.
// No dependencies; included by the top level only.
`ifndef FIRST_FIT_BLOCK_ALLOCATOR_DEFINES_SVH
`define FIRST_FIT_BLOCK_ALLOCATOR_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define FFBA_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("allocator check failed in the same cycle");

// The consequent must hold in the cycle after the antecedent.
`define FFBA_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("allocator check failed one cycle later");

`endif

>>> hw/rtl/ffba_pkg.sv
// Package for the first-fit block allocator: sizes, header and result types, states.
// No dependencies; used by the walker, the top level and the testbench.
package ffba_pkg;

  localparam int ARENA_BYTES       = 65536;
  localparam int HEADER_BYTES      = 24;
  localparam int ALIGN_MASK        = 15;
  localparam int MIN_SPLIT_PAYLOAD = 16;
  localparam int HDR_GRAIN         = 8;
  localparam int STORE_DEPTH       = ARENA_BYTES / HDR_GRAIN;

  localparam int OFF_W   = $clog2(ARENA_BYTES);
  localparam int IDX_LSB = $clog2(HDR_GRAIN);
  localparam int IDX_W   = OFF_W - IDX_LSB;
  localparam int SIZE_W  = OFF_W;
  localparam int REQ_W   = 24;
  localparam int NEED_W  = REQ_W + 1;

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  typedef struct packed {
    logic              is_free;
    logic [SIZE_W-1:0] size;
  } hdr_t;

  typedef struct packed {
    logic             ok;
    logic [OFF_W-1:0] offset;
  } res_t;

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_WALK,
    S_MERGE,
    S_SPLIT,
    S_DONE
  } state_t;

endpackage

>>> hw/rtl/ffba_hdr_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies; holds the block headers of the allocator.
module ffba_hdr_ram #(
  parameter int DEPTH = 8192,
  parameter int WIDTH = 17
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> hw/rtl/ffba_walker.sv
// Header walker: sequencer that reads, modifies and writes back block headers.
// Depends on ffba_pkg and ffba_hdr_ram.
module ffba_walker (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic                             cmd,
  input  logic [ffba_pkg::REQ_W-1:0]       req_bytes,
  input  logic [ffba_pkg::OFF_W-1:0]       free_offset,
  output logic                             res_valid,
  output ffba_pkg::res_t                   res,
  input  logic                             res_take
);
  import ffba_pkg::*;

  state_t            state, state_next;
  logic              op_free, op_free_next;
  logic [NEED_W-1:0] need, need_next;
  logic [OFF_W-1:0]  free_off, free_off_next;
  logic [OFF_W-1:0]  cur_start, cur_start_next;
  logic [SIZE_W-1:0] cur_size, cur_size_next;
  logic [OFF_W-1:0]  aux_start, aux_start_next;
  logic [SIZE_W-1:0] aux_size, aux_size_next;
  res_t              res_q, res_next;

  logic              we, re;
  logic [IDX_W-1:0]  waddr, raddr;
  hdr_t              wdata;
  logic [$bits(hdr_t)-1:0] rdata;
  hdr_t              rd;

  logic [OFF_W:0]    pay_ptr, end_ptr;
  logic              has_next, fits, can_split, match, passed;
  logic [NEED_W-1:0] need_in;

  ffba_hdr_ram #(
    .DEPTH(STORE_DEPTH),
    .WIDTH($bits(hdr_t))
  ) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .re   (re),
    .raddr(raddr),
    .rdata(rdata)
  );

  assign rd        = hdr_t'(rdata);
  assign pay_ptr   = (OFF_W+1)'(cur_start) + (OFF_W+1)'(HEADER_BYTES);
  assign end_ptr   = pay_ptr + (OFF_W+1)'(rd.size);
  assign has_next  = end_ptr < (OFF_W+1)'(ARENA_BYTES);
  assign fits      = rd.is_free && (NEED_W'(rd.size) >= need);
  assign can_split = (NEED_W+1)'(rd.size) >=
                     (NEED_W+1)'(need) + (NEED_W+1)'(HEADER_BYTES + MIN_SPLIT_PAYLOAD);
  assign match     = (OFF_W+1)'(free_off) == pay_ptr;
  assign passed    = (OFF_W+1)'(free_off) < pay_ptr;
  assign need_in   = (NEED_W'(req_bytes) + NEED_W'(ALIGN_MASK)) & ~NEED_W'(ALIGN_MASK);

  assign in_stall  = (state != S_IDLE);
  assign res_valid = (state == S_DONE);
  assign res       = res_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    op_free   <= op_free_next;
    need      <= need_next;
    free_off  <= free_off_next;
    cur_start <= cur_start_next;
    cur_size  <= cur_size_next;
    aux_start <= aux_start_next;
    aux_size  <= aux_size_next;
    res_q     <= res_next;
  end

  always_comb begin
    state_next     = state;
    op_free_next   = op_free;
    need_next      = need;
    free_off_next  = free_off;
    cur_start_next = cur_start;
    cur_size_next  = cur_size;
    aux_start_next = aux_start;
    aux_size_next  = aux_size;
    res_next       = res_q;
    we             = 1'b0;
    waddr          = cur_start[OFF_W-1:IDX_LSB];
    wdata          = '{is_free: 1'b1, size: rd.size};
    re             = 1'b0;
    raddr          = end_ptr[OFF_W-1:IDX_LSB];

    case (state)
      S_INIT: begin
        we         = 1'b1;
        waddr      = '0;
        wdata      = '{is_free: 1'b1, size: SIZE_W'(ARENA_BYTES - HEADER_BYTES)};
        state_next = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          op_free_next   = (cmd == CMD_FREE);
          need_next      = need_in;
          free_off_next  = free_offset;
          cur_start_next = '0;
          if (cmd == CMD_ALLOC && req_bytes == '0) begin
            res_next   = '{ok: 1'b0, offset: '0};
            state_next = S_DONE;
          end else begin
            re         = 1'b1;
            raddr      = '0;
            state_next = S_WALK;
          end
        end
      end
      S_WALK: begin
        if (!op_free) begin
          if (fits) begin
            we       = 1'b1;
            res_next = '{ok: 1'b1, offset: pay_ptr[OFF_W-1:0]};
            if (can_split) begin
              wdata          = '{is_free: 1'b0, size: need[SIZE_W-1:0]};
              aux_start_next = OFF_W'(pay_ptr + (OFF_W+1)'(need[SIZE_W-1:0]));
              aux_size_next  = rd.size - need[SIZE_W-1:0] - SIZE_W'(HEADER_BYTES);
              state_next     = S_SPLIT;
            end else begin
              wdata      = '{is_free: 1'b0, size: rd.size};
              state_next = S_DONE;
            end
          end else if (has_next) begin
            re             = 1'b1;
            cur_start_next = end_ptr[OFF_W-1:0];
          end else begin
            res_next   = '{ok: 1'b0, offset: '0};
            state_next = S_DONE;
          end
        end else begin
          if (match) begin
            res_next = '{ok: 1'b1, offset: '0};
            if (has_next) begin
              re            = 1'b1;
              cur_size_next = rd.size;
              state_next    = S_MERGE;
            end else begin
              we         = 1'b1;
              state_next = S_DONE;
            end
          end else if (passed || !has_next) begin
            res_next   = '{ok: 1'b0, offset: '0};
            state_next = S_DONE;
          end else begin
            re             = 1'b1;
            cur_start_next = end_ptr[OFF_W-1:0];
          end
        end
      end
      S_MERGE: begin
        we = 1'b1;
        if (rd.is_free) begin
          wdata = '{is_free: 1'b1,
                    size: cur_size + SIZE_W'(HEADER_BYTES) + rd.size};
        end else begin
          wdata = '{is_free: 1'b1, size: cur_size};
        end
        state_next = S_DONE;
      end
      S_SPLIT: begin
        we         = 1'b1;
        waddr      = aux_start[OFF_W-1:IDX_LSB];
        wdata      = '{is_free: 1'b1, size: aux_size};
        state_next = S_DONE;
      end
      S_DONE: begin
        if (res_take) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_INIT;
      end
    endcase
  end

endmodule

>>> hw/rtl/first_fit_block_allocator.sv
// Top level of the first-fit block allocator: header walker plus output register.
// Depends on ffba_pkg, ffba_walker and first_fit_block_allocator_defines.svh.
//
//  channel | direction | handshake          | fields
//  in      | input     | in_valid/in_stall  | cmd, req_bytes, free_offset
//  out     | output    | out_valid/out_stall| ok, payload_offset
//
// A request is accepted in S_IDLE and then walks the headers, one header read per
// cycle on the RAM read port, until a fit, a match, a passed offset or the arena
// end; a split adds the S_SPLIT state and a free that checks its successor adds S_MERGE.
// A zero-size allocate skips the walk and goes straight to S_DONE.
// After rst falls, S_INIT writes the initial header; in_stall is high meanwhile.
// A beat can be accepted while the previous result waits in the output register.
module first_fit_block_allocator (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic                       cmd,
  input  logic [ffba_pkg::REQ_W-1:0] req_bytes,
  input  logic [ffba_pkg::OFF_W-1:0] free_offset,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic                       ok,
  output logic [ffba_pkg::OFF_W-1:0] payload_offset
);
  import ffba_pkg::*;

  `include "first_fit_block_allocator_defines.svh"

  logic res_valid, res_take;
  res_t res;

  assign res_take = res_valid && (!out_valid || !out_stall);

  ffba_walker u_walker (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .cmd        (cmd),
    .req_bytes  (req_bytes),
    .free_offset(free_offset),
    .res_valid  (res_valid),
    .res        (res),
    .res_take   (res_take)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_take) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      ok             <= res.ok;
      payload_offset <= res.offset;
    end
  end

  `FFBA_ASSERT_NXT(a_one_in_flight, clk, rst, in_valid && !in_stall, in_stall)
  `FFBA_ASSERT_NXT(a_result_waits, clk, rst, res_valid && !res_take, res_valid)
  `FFBA_ASSERT_NOW(a_offset_only_on_success, clk, rst,
                   out_valid && payload_offset != '0, ok && payload_offset[2:0] == 3'b000)
  `FFBA_ASSERT_NOW(a_no_result_while_idle, clk, rst, !in_stall, !res_valid)

endmodule

>>> dv/tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for first_fit_block_allocator: directed and random beats.
// Depends on ffba_pkg and the allocator RTL; tracks the arena in its own block list.
module tb;
  import ffba_pkg::*;

  localparam int WATCHDOG_LIMIT = 50000;

  typedef struct {
    int unsigned start;
    int unsigned size;
    bit          is_free;
  } arena_block_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic              cmd = CMD_ALLOC;
  logic [REQ_W-1:0]  req_bytes = '0;
  logic [OFF_W-1:0]  free_offset = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic              ok;
  logic [OFF_W-1:0]  payload_offset;

  arena_block_t      arena_blocks[$];
  res_t              pending_outcomes[$];
  logic [OFF_W-1:0]  live_offsets[$];
  logic [OFF_W-1:0]  freed_offsets[$];
  int                gap_pct = 0;
  int                stall_pct = 0;
  int                mismatch_count = 0;
  int                quiet_cycles = 0;

  first_fit_block_allocator DUT (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .cmd            (cmd),
    .req_bytes      (req_bytes),
    .free_offset    (free_offset),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .ok             (ok),
    .payload_offset (payload_offset)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic void reset_arena_model();
    arena_block_t whole;
    whole.start = 0;
    whole.size = ARENA_BYTES - HEADER_BYTES;
    whole.is_free = 1'b1;
    arena_blocks.delete();
    arena_blocks.push_back(whole);
  endfunction

  function automatic res_t first_fit_alloc(input logic [REQ_W-1:0] bytes_in);
    res_t r;
    arena_block_t rest;
    int unsigned req32;
    int unsigned need;
    r = '0;
    req32 = bytes_in;
    if (req32 == 0) begin
      return r;
    end
    need = (req32 + ALIGN_MASK) & ~ALIGN_MASK;
    for (int i = 0; i < arena_blocks.size(); i++) begin
      if (arena_blocks[i].is_free && arena_blocks[i].size >= need) begin
        if (arena_blocks[i].size >= need + HEADER_BYTES + MIN_SPLIT_PAYLOAD &&
            arena_blocks.size() < STORE_DEPTH) begin
          rest.start = arena_blocks[i].start + HEADER_BYTES + need;
          rest.size = arena_blocks[i].size - need - HEADER_BYTES;
          rest.is_free = 1'b1;
          arena_blocks.insert(i + 1, rest);
          arena_blocks[i].size = need;
        end
        arena_blocks[i].is_free = 1'b0;
        r.ok = 1'b1;
        r.offset = OFF_W'(arena_blocks[i].start + HEADER_BYTES);
        return r;
      end
    end
    return r;
  endfunction

  function automatic res_t release_block(input logic [OFF_W-1:0] off_in);
    res_t r;
    r = '0;
    for (int i = 0; i < arena_blocks.size(); i++) begin
      if (arena_blocks[i].start + HEADER_BYTES == off_in) begin
        arena_blocks[i].is_free = 1'b1;
        if (i + 1 < arena_blocks.size() && arena_blocks[i + 1].is_free) begin
          arena_blocks[i].size = arena_blocks[i].size + HEADER_BYTES +
                                 arena_blocks[i + 1].size;
          arena_blocks.delete(i + 1);
        end
        r.ok = 1'b1;
        return r;
      end
    end
    return r;
  endfunction

  task automatic send_beat(input logic op, input logic [REQ_W-1:0] bytes_in,
                           input logic [OFF_W-1:0] off_in);
    res_t outcome;
    int idx[$];
    if (gap_pct > 0 && $urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < gap_pct);
    end
    in_valid <= 1'b1;
    cmd <= op;
    req_bytes <= bytes_in;
    free_offset <= off_in;
    do @(posedge clk); while (in_stall);
    if (op == CMD_ALLOC) begin
      outcome = first_fit_alloc(bytes_in);
    end else begin
      outcome = release_block(off_in);
    end
    pending_outcomes.push_back(outcome);
    if (outcome.ok && op == CMD_ALLOC) begin
      live_offsets.push_back(outcome.offset);
    end
    if (outcome.ok && op == CMD_FREE) begin
      idx = live_offsets.find_first_index(x) with (x == off_in);
      if (idx.size() != 0) begin
        live_offsets.delete(idx[0]);
      end
      freed_offsets.push_back(off_in);
      if (freed_offsets.size() > 32) begin
        void'(freed_offsets.pop_front());
      end
    end
  endtask

  task automatic wait_until_drained();
    in_valid <= 1'b0;
    while (pending_outcomes.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic test_alloc_corners();
    send_beat(CMD_ALLOC, '0, '1);
    send_beat(CMD_ALLOC, '1, '0);
    send_beat(CMD_ALLOC, REQ_W'(ARENA_BYTES - HEADER_BYTES + 1), '0);
    send_beat(CMD_ALLOC, REQ_W'(ARENA_BYTES - HEADER_BYTES), '0);
    send_beat(CMD_ALLOC, REQ_W'(1), '0);
    send_beat(CMD_FREE, '0, OFF_W'(HEADER_BYTES));
    send_beat(CMD_ALLOC, REQ_W'(1), '0);
    send_beat(CMD_ALLOC, REQ_W'(16), '0);
    send_beat(CMD_ALLOC, REQ_W'(17), '0);
  endtask

  task automatic test_free_and_merge();
    send_beat(CMD_FREE, '1, '1);
    send_beat(CMD_FREE, '0, '0);
    send_beat(CMD_FREE, '0, OFF_W'(64));
    send_beat(CMD_FREE, '0, OFF_W'(64));
    send_beat(CMD_FREE, '0, OFF_W'(104));
    send_beat(CMD_FREE, '0, OFF_W'(64));
    send_beat(CMD_FREE, '0, OFF_W'(HEADER_BYTES));
  endtask

  task automatic test_split_threshold();
    int unsigned whole;
    whole = ARENA_BYTES - HEADER_BYTES;
    send_beat(CMD_ALLOC, REQ_W'(whole - 32), '0);
    send_beat(CMD_ALLOC, REQ_W'(16), '0);
    send_beat(CMD_FREE, '0, OFF_W'(HEADER_BYTES));
    send_beat(CMD_ALLOC, REQ_W'(whole - HEADER_BYTES - MIN_SPLIT_PAYLOAD), '0);
    send_beat(CMD_ALLOC, REQ_W'(16), '0);
    send_beat(CMD_FREE, '0, OFF_W'(whole - MIN_SPLIT_PAYLOAD + HEADER_BYTES));
    send_beat(CMD_FREE, '0, OFF_W'(HEADER_BYTES));
  endtask

  task automatic test_random_traffic(input int beats, input int gap, input int hold);
    int unsigned roll;
    int unsigned alloc_pct;
    logic [REQ_W-1:0] bytes_pick;
    logic [OFF_W-1:0] off_pick;
    gap_pct = gap;
    stall_pct = hold;
    repeat (beats) begin
      alloc_pct = live_offsets.size() < 8 ? 80 : (live_offsets.size() > 48 ? 25 : 55);
      roll = $urandom_range(99);
      if (roll < alloc_pct || live_offsets.size() == 0) begin
        roll = $urandom_range(99);
        if (roll < 2) begin
          bytes_pick = '0;
        end else if (roll < 72) begin
          bytes_pick = REQ_W'($urandom_range(256, 1));
        end else if (roll < 92) begin
          bytes_pick = REQ_W'($urandom_range(2048, 257));
        end else if (roll < 96) begin
          bytes_pick = REQ_W'($urandom_range(16384, 2049));
        end else begin
          bytes_pick = REQ_W'($urandom);
        end
        send_beat(CMD_ALLOC, bytes_pick, OFF_W'($urandom));
      end else begin
        roll = $urandom_range(99);
        if (roll < 85) begin
          off_pick = live_offsets[$urandom_range(live_offsets.size() - 1)];
        end else if (roll < 93 && freed_offsets.size() != 0) begin
          off_pick = freed_offsets[$urandom_range(freed_offsets.size() - 1)];
        end else begin
          off_pick = OFF_W'($urandom);
        end
        send_beat(CMD_FREE, REQ_W'($urandom), off_pick);
      end
    end
    wait_until_drained();
  endtask

  always @(posedge clk) begin : check_results
    res_t want;
    out_stall <= (stall_pct > 0) && ($urandom_range(99) < stall_pct);
    if (!rst && out_valid && !out_stall) begin
      if (pending_outcomes.size() == 0) begin
        $display("%0t: unexpected beat, expected none, actual ok %0d offset %0d",
                 $time, ok, payload_offset);
        mismatch_count++;
      end else begin
        want = pending_outcomes.pop_front();
        if (ok !== want.ok) begin
          $display("%0t: ok mismatch, expected %0d actual %0d", $time, want.ok, ok);
          mismatch_count++;
        end
        if (payload_offset !== want.offset) begin
          $display("%0t: payload_offset mismatch, expected %0d actual %0d",
                   $time, want.offset, payload_offset);
          mismatch_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    reset_arena_model();
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    test_alloc_corners();
    test_free_and_merge();
    test_split_threshold();
    wait_until_drained();
    test_random_traffic(212, 0, 0);
    test_random_traffic(212, 48, 0);
    test_random_traffic(212, 0, 48);
    test_random_traffic(212, 15, 15);
    repeat (40) @(posedge clk);
    if (mismatch_count == 0 && pending_outcomes.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
